[rtl/core/awck_pkg.sv]
package awck_pkg;

    // request kinds; code 3 is unused and behaves as a read
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_SYNC = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_START_DELAY    = 2'd0;
    localparam logic [1:0] REG_RESYNC_PERIOD  = 2'd1;
    localparam logic [1:0] REG_RELIABLE_TMO   = 2'd2;
    localparam logic [1:0] REG_DEFAULT_ANCHOR = 2'd3;

    localparam int unsigned MS_W   = 32;
    localparam int unsigned SEC_W  = 40;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 64;

    localparam logic [MS_W-1:0]  START_DELAY_RST    = 32'd240000;
    localparam logic [MS_W-1:0]  RESYNC_PERIOD_RST  = 32'd10800000;
    localparam logic [MS_W-1:0]  RELIABLE_TMO_RST   = 32'd86400000;
    localparam logic [SEC_W-1:0] DEFAULT_ANCHOR_RST = 40'd1735731000;

    // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
    localparam int unsigned       MAGIC_W   = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'h10624DD3;
    localparam int unsigned       DIV_SHIFT = 38;
    localparam int unsigned       PROD_W    = MS_W + MAGIC_W;
    localparam int unsigned       QUO_W     = PROD_W - DIV_SHIFT;

    typedef struct packed {
        logic [1:0]       func;
        logic [MS_W-1:0]  now_ms;
        logic             rtc_ok;
        logic [SEC_W-1:0] time_seconds;
    } req_t;

    typedef struct packed {
        logic [SEC_W-1:0] timestamp;
        logic             available;
        logic             reliable;
    } res_t;

    // handed from the state stage to the timestamp pipe
    typedef struct packed {
        logic [SEC_W-1:0] base_seconds;
        logic [MS_W-1:0]  elapsed_ms;
        logic             available;
        logic             reliable;
    } stamp_t;

endpackage

[rtl/core/awck_stamp.sv]
module awck_stamp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            st_valid,
    output logic            st_ready,
    input  awck_pkg::stamp_t st,
    output logic            res_valid,
    input  logic            res_ready,
    output awck_pkg::res_t  res
);
    import awck_pkg::*;

    stamp_t              s1_reg;
    logic                s1_valid_reg;
    logic [QUO_W-1:0]    s2_quo_reg;
    logic [SEC_W-1:0]    s2_base_reg;
    logic                s2_avail_reg;
    logic                s2_rel_reg;
    logic                s2_valid_reg;
    res_t                out_reg;
    logic                out_valid_reg;

    logic                out_free;
    logic                s2_free;
    logic [PROD_W-1:0]   prod;

    assign out_free = !out_valid_reg || res_ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign st_ready = !s1_valid_reg || s2_free;

    // reciprocal multiply for the /1000
    assign prod = PROD_W'(s1_reg.elapsed_ms) * PROD_W'(DIV_MAGIC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st_ready)
                s1_valid_reg <= st_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_ready && st_valid)
            s1_reg <= st;
        if (s2_free && s1_valid_reg)
        begin
            s2_quo_reg   <= prod[PROD_W-1:DIV_SHIFT];
            s2_base_reg  <= s1_reg.base_seconds;
            s2_avail_reg <= s1_reg.available;
            s2_rel_reg   <= s1_reg.reliable;
        end
        if (out_free && s2_valid_reg)
        begin
            out_reg.timestamp <= s2_base_reg + SEC_W'(s2_quo_reg);
            out_reg.available <= s2_avail_reg;
            out_reg.reliable  <= s2_rel_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

[rtl/core/anchored_wall_clock_keeper_unit.sv]
// Channel   | Signals                        | Payload
// ----------+--------------------------------+----------------------------------------
// request   | req_valid / req_ready / req    | func, now_ms, rtc_ok, time_seconds
// result    | res_valid / res_ready / res    | timestamp, available, reliable
// config    | psel penable pwrite paddr pwdata prdata pready (APB, 64-bit, regs at 8*i)
//
// One request per cycle sustained while res_ready stays high; an accepted request
// moves from the request register through the stamp, quotient and result registers.
// Stages: request register, state update (clock state written as the request
// leaves it), reciprocal multiply for the /1000, add to anchor into the result register.
// Clock state is written as a request leaves, so back-to-back requests see its update.
// Stalls: each stage moves when the one after it is empty or moving; res_ready
// reaches req_ready combinationally. rst_n (async, low) empties the pipe and
// returns clock state to zero and registers to their defaults.
module anchored_wall_clock_keeper_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  awck_pkg::req_t             req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output awck_pkg::res_t             res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [awck_pkg::ADDR_W-1:0] paddr,
    input  logic [awck_pkg::DATA_W-1:0] pwdata,
    output logic [awck_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import awck_pkg::*;

    // configuration
    logic [MS_W-1:0]  start_delay_reg;
    logic [MS_W-1:0]  resync_period_reg;
    logic [MS_W-1:0]  reliable_tmo_reg;
    logic [SEC_W-1:0] default_anchor_reg;
    logic             cfg_wr;

    // request register
    req_t             s0_reg;
    logic             s0_valid_reg;
    logic             s0_move;

    // clock state
    logic [SEC_W-1:0] anchor_sec_reg, anchor_sec_next;
    logic [MS_W-1:0]  anchor_ms_reg, anchor_ms_next;
    logic [MS_W-1:0]  last_sync_reg, last_sync_next;
    logic [MS_W-1:0]  last_rtc_reg, last_rtc_next;
    logic             avail_reg, avail_next;
    logic             rel_reg, rel_next;

    logic [MS_W-1:0]  since_rtc;
    logic [MS_W-1:0]  since_sync;
    stamp_t           st;
    logic             st_ready;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg    <= START_DELAY_RST;
            resync_period_reg  <= RESYNC_PERIOD_RST;
            reliable_tmo_reg   <= RELIABLE_TMO_RST;
            default_anchor_reg <= DEFAULT_ANCHOR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_START_DELAY:    start_delay_reg    <= pwdata[MS_W-1:0];
                REG_RESYNC_PERIOD:  resync_period_reg  <= pwdata[MS_W-1:0];
                REG_RELIABLE_TMO:   reliable_tmo_reg   <= pwdata[MS_W-1:0];
                REG_DEFAULT_ANCHOR: default_anchor_reg <= pwdata[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_START_DELAY:    prdata = DATA_W'(start_delay_reg);
            REG_RESYNC_PERIOD:  prdata = DATA_W'(resync_period_reg);
            REG_RELIABLE_TMO:   prdata = DATA_W'(reliable_tmo_reg);
            REG_DEFAULT_ANCHOR: prdata = DATA_W'(default_anchor_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------ request stage
    assign req_ready = !s0_valid_reg || st_ready;
    assign s0_move   = s0_valid_reg && st_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (req_ready)
            s0_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            s0_reg <= req;
    end

    // ------------------------------------------------------- state update
    // All elapsed times are modulo-2^32 differences.
    assign since_rtc = s0_reg.now_ms - last_rtc_reg;

    always_comb
    begin
        anchor_sec_next = anchor_sec_reg;
        anchor_ms_next  = anchor_ms_reg;
        last_sync_next  = last_sync_reg;
        last_rtc_next   = last_rtc_reg;
        avail_next      = avail_reg;
        rel_next        = rel_reg;

        case (s0_reg.func)
            FUNC_TICK:
            begin
                if (!avail_reg)
                begin
                    // start delay is against the raw count, not a difference
                    if (s0_reg.now_ms >= start_delay_reg)
                    begin
                        anchor_ms_next = s0_reg.now_ms;
                        last_rtc_next  = s0_reg.now_ms;
                        avail_next     = 1'b1;
                        if (s0_reg.rtc_ok)
                        begin
                            anchor_sec_next = s0_reg.time_seconds;
                            last_sync_next  = s0_reg.now_ms;
                            rel_next        = 1'b1;
                        end
                        else
                        begin
                            anchor_sec_next = default_anchor_reg;
                            last_sync_next  = '0;
                            rel_next        = 1'b0;
                        end
                    end
                end
                else if (since_rtc >= resync_period_reg)
                begin
                    // resync instant taken even on a bad reading
                    last_rtc_next = s0_reg.now_ms;
                    if (s0_reg.rtc_ok)
                    begin
                        anchor_sec_next = s0_reg.time_seconds;
                        anchor_ms_next  = s0_reg.now_ms;
                        last_sync_next  = s0_reg.now_ms;
                        rel_next        = 1'b1;
                    end
                end
            end
            FUNC_SYNC:
            begin
                anchor_sec_next = s0_reg.time_seconds;
                anchor_ms_next  = s0_reg.now_ms;
                last_sync_next  = s0_reg.now_ms;
                avail_next      = 1'b1;
                rel_next        = 1'b1;
            end
            default: ;
        endcase

        // timeout sees the last sync after any resync above
        since_sync = s0_reg.now_ms - last_sync_next;
        if (s0_reg.func == FUNC_TICK && avail_reg && rel_next
            && since_sync >= reliable_tmo_reg)
            rel_next = 1'b0;

        // before an anchor the raw count goes out as the timestamp
        if (avail_next)
        begin
            st.base_seconds = anchor_sec_next;
            st.elapsed_ms   = s0_reg.now_ms - anchor_ms_next;
            st.available    = 1'b1;
            st.reliable     = rel_next;
        end
        else
        begin
            st.base_seconds = SEC_W'(s0_reg.now_ms);
            st.elapsed_ms   = '0;
            st.available    = 1'b0;
            st.reliable     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_sec_reg <= '0;
            anchor_ms_reg  <= '0;
            last_sync_reg  <= '0;
            last_rtc_reg   <= '0;
            avail_reg      <= 1'b0;
            rel_reg        <= 1'b0;
        end
        else if (s0_move)
        begin
            anchor_sec_reg <= anchor_sec_next;
            anchor_ms_reg  <= anchor_ms_next;
            last_sync_reg  <= last_sync_next;
            last_rtc_reg   <= last_rtc_next;
            avail_reg      <= avail_next;
            rel_reg        <= rel_next;
        end
    end

    // ------------------------------------------------- timestamp pipeline
    awck_stamp u_stamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .st_valid  (s0_valid_reg),
        .st_ready  (st_ready),
        .st        (st),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

`ifndef NO_ASSERTIONS
    // once anchored the clock never loses its anchor
    a_avail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        avail_reg |=> avail_reg)
        else $error("available flag dropped");

    // reliable only ever set on an anchored clock
    a_rel_needs_avail: assert property (@(posedge clk) disable iff (!rst_n)
        rel_reg |-> avail_reg)
        else $error("reliable without anchor");

    // an unanchored result never claims reliability
    a_res_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.available) |-> !res.reliable)
        else $error("reliable result while unavailable");

    // state only moves when a request leaves the request register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s0_move |=> ($stable(anchor_ms_reg) && $stable(last_rtc_reg)))
        else $error("clock state changed without a request");
`endif

endmodule
